/* hdl/added_mass_pair_block_defines.svh */
// assertion macros for the added-mass pair block
// used by the top level only, expects clk and rst_n in scope
`ifndef ADDED_MASS_PAIR_BLOCK_DEFINES_SVH
`define ADDED_MASS_PAIR_BLOCK_DEFINES_SVH

// expression holds at every clock edge out of reset
`define AMP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AMP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/amp_pkg.sv */
// shared types and constants of the added-mass pair block
// no dependencies
`timescale 1ns / 1ps

package amp_pkg;

  // register port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int POS_W    = 32;
  localparam int MAG_W    = POS_W + 1;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int SUM_W    = PROD_W;
  localparam int SQRT_SH  = 32;
  localparam int RAD_W    = SUM_W + SQRT_SH;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int ISO_W    = CFG_W + SUM_W;
  localparam int DY_W     = CFG_W + PROD_W;
  localparam int DIFF_W   = ISO_W + 1;
  localparam int SCL_W    = CFG_W + DIFF_W;
  localparam int FRAC_SH  = 48;
  localparam int NUM_W    = SCL_W + FRAC_SH;
  localparam int SQ_W     = 2 * SUM_W;
  localparam int DEN_W    = SQ_W + ROOT_W;
  localparam int ENT_W    = 32;
  localparam int STAT_W   = 2;

  // latencies of the submodules
  localparam int MUL_LAT  = 3;
  localparam int DIV_LAT  = ENT_W + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASS_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_RR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ISO   = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] MASS_SCALE_RST = 32'd65536;
  localparam logic [CFG_W-1:0] COEF_RR_RST    = 32'd98304;
  localparam logic [CFG_W-1:0] COEF_ISO_RST   = 32'd32768;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_COINC = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

  // saturation limits
  localparam logic [ENT_W-1:0] ENT_MAX = 32'h7FFF_FFFF;
  localparam logic [ENT_W-1:0] ENT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_a_z;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [POS_W-1:0] pos_b_z;
    logic                    last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] m_xx;
    logic signed [ENT_W-1:0] m_xy;
    logic signed [ENT_W-1:0] m_xz;
    logic signed [ENT_W-1:0] m_yy;
    logic signed [ENT_W-1:0] m_yz;
    logic signed [ENT_W-1:0] m_zz;
    logic [STAT_W-1:0]       pair_status;
    logic                    last_out;
  } out_item_t;

endpackage

/* hdl/amp_mul.sv */
// pipelined unsigned multiplier built from 32x32 partial products
// three register stages; depends on nothing
`timescale 1ns / 1ps

module amp_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic             clk,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int LA = (WA + 31) / 32;
  localparam int LB = (WB + 31) / 32;
  localparam int RW = LB * 32 + 32;
  localparam int SW = LA * 32 + LB * 32;
  localparam int PW = WA + WB;

  logic [LA*32-1:0] a_ext;
  logic [LB*32-1:0] b_ext;
  logic [63:0]      pp_r [LA][LB];
  logic [RW-1:0]    row_nxt [LA];
  logic [RW-1:0]    row_r [LA];
  logic [SW-1:0]    sum_nxt;
  logic [PW-1:0]    p_r;

  assign a_ext = (LA*32)'(a);
  assign b_ext = (LB*32)'(b);

  // stage one: limb products
  always_ff @(posedge clk) begin
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LB; j++) begin
        pp_r[i][j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
      end
    end
  end

  // stage two: one row sum per limb of a
  always_comb begin
    for (int i = 0; i < LA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < LB; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (32 * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LA; i++) begin
      row_r[i] <= row_nxt[i];
    end
  end

  // stage three: add the rows
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < LA; i++) begin
      sum_nxt = sum_nxt + (SW'(row_r[i]) << (32 * i));
    end
  end

  always_ff @(posedge clk) begin
    p_r <= sum_nxt[PW-1:0];
  end

  assign p = p_r;

endmodule

/* hdl/amp_div.sv */
// pipelined restoring divider with signed saturation to one entry
// one quotient bit per stage; depends on amp_pkg
`timescale 1ns / 1ps

module amp_div (
  input  logic                              clk,
  input  logic [amp_pkg::NUM_W-1:0]         num,
  input  logic [amp_pkg::DEN_W-1:0]         den,
  input  logic                              neg,
  output logic signed [amp_pkg::ENT_W-1:0]  entry,
  output logic                              sat
);

  localparam int QB = amp_pkg::ENT_W;
  localparam int XW = amp_pkg::DEN_W + QB;

  logic [amp_pkg::NUM_W-1:0] rem_r [QB+1];
  logic [QB-1:0]             q_r   [QB+1];
  logic [amp_pkg::DEN_W-1:0] den_r [QB+1];
  logic [QB:0]               neg_r;
  logic [QB:0]               ovf_r;
  logic [amp_pkg::NUM_W-1:0] rem_nxt [1:QB];
  logic [QB-1:0]             q_nxt   [1:QB];
  logic [XW-1:0]             sh;
  logic [amp_pkg::ENT_W-1:0] entry_nxt, entry_r;
  logic                      sat_nxt, sat_r;

  // one quotient bit per stage, most significant first
  always_comb begin
    sh = '0;
    for (int m = 1; m <= QB; m++) begin
      sh = XW'(den_r[m-1]) << (QB - m);
      if (XW'(rem_r[m-1]) >= sh) begin
        rem_nxt[m] = rem_r[m-1] - sh[amp_pkg::NUM_W-1:0];
        q_nxt[m]   = q_r[m-1] | (QB'(1) << (QB - m));
      end else begin
        rem_nxt[m] = rem_r[m-1];
        q_nxt[m]   = q_r[m-1];
      end
    end
  end

  // saturate and apply the sign
  always_comb begin
    sat_nxt   = 1'b0;
    entry_nxt = q_r[QB];
    priority if (ovf_r[QB]) begin
      sat_nxt   = 1'b1;
      entry_nxt = neg_r[QB] ? amp_pkg::ENT_MIN : amp_pkg::ENT_MAX;
    end else if (neg_r[QB] && (q_r[QB] > amp_pkg::ENT_MIN)) begin
      sat_nxt   = 1'b1;
      entry_nxt = amp_pkg::ENT_MIN;
    end else if (neg_r[QB]) begin
      entry_nxt = '0 - q_r[QB];
    end else if (q_r[QB] > amp_pkg::ENT_MAX) begin
      sat_nxt   = 1'b1;
      entry_nxt = amp_pkg::ENT_MAX;
    end else begin
      entry_nxt = q_r[QB];
    end
  end

  // pipeline registers, quotient overflow checked on entry
  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    q_r[0]   <= '0;
    den_r[0] <= den;
    neg_r[0] <= neg;
    ovf_r[0] <= XW'(num) >= (XW'(den) << QB);
    for (int m = 1; m <= QB; m++) begin
      rem_r[m] <= rem_nxt[m];
      q_r[m]   <= q_nxt[m];
      den_r[m] <= den_r[m-1];
      neg_r[m] <= neg_r[m-1];
      ovf_r[m] <= ovf_r[m-1];
    end
    entry_r <= entry_nxt;
    sat_r   <= sat_nxt;
  end

  assign entry = entry_r;
  assign sat   = sat_r;

endmodule

/* hdl/added_mass_pair_block.sv */
// added-mass pair block: six entries of the off-diagonal 3x3 block per sphere pair
// results leave through the output queue on out_valid in request order
// throughput: one request per cycle while in_stall is low; up to FIFO_DEPTH requests in flight,
// set by the output queue that holds results while out_stall is high
// reset: synchronous, clears valid bits, counters and sets the gain registers to defaults
`timescale 1ns / 1ps
`include "added_mass_pair_block_defines.svh"

module added_mass_pair_block #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  amp_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output amp_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [amp_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [amp_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int NENT  = 6;

  // stage numbers
  localparam int ST_S    = 3;
  localparam int SQ_N    = amp_pkg::ROOT_W;
  localparam int ST_D    = ST_S + SQ_N;
  localparam int ST_DY   = ST_S + amp_pkg::MUL_LAT;
  localparam int ST_SS   = ST_S + amp_pkg::MUL_LAT;
  localparam int ST_DIFF = ST_DY + 1;
  localparam int ST_SCL  = ST_DIFF + amp_pkg::MUL_LAT;
  localparam int ST_DEN  = ST_D + amp_pkg::MUL_LAT;
  localparam int ST_RES  = ST_DEN + amp_pkg::DIV_LAT;
  localparam int SS_DLY  = ST_D - ST_SS;
  localparam int NUM_DLY = ST_DEN - ST_SCL;
  localparam int ONEG_W  = ST_DEN - ST_DIFF + 1;
  localparam int SQR_W   = amp_pkg::ROOT_W + 4;

  // entry order xx xy xz yy yz zz
  localparam int PICK_I [NENT] = '{0, 0, 0, 1, 1, 2};
  localparam int PICK_J [NENT] = '{0, 1, 2, 1, 2, 2};
  localparam int ENT_XX = 0;
  localparam int ENT_YY = 3;
  localparam int ENT_ZZ = 5;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    logic       last;
  } ctl_t;

  // registers
  logic [amp_pkg::CFG_W-1:0] mass_scale_r, coef_rr_r, coef_iso_r;

  logic                      in_acc;
  logic                      out_acc;
  logic [ST_RES:1]           vld_r;
  ctl_t                      ctl_r [1:ST_RES];

  logic signed [amp_pkg::MAG_W-1:0] dif [3];
  logic [amp_pkg::MAG_W-1:0]  mag_nxt [3];
  logic [amp_pkg::MAG_W-1:0]  mag1_r [3];
  logic [amp_pkg::PROD_W-1:0] prod2_r [NENT];
  logic [amp_pkg::PROD_W-1:0] prod3_r [NENT];
  logic [amp_pkg::SUM_W-1:0]  s_nxt, s3_r;

  logic [SQR_W-1:0]           sq_rem_r  [SQ_N];
  logic [amp_pkg::ROOT_W-1:0] sq_root_r [SQ_N];
  logic [amp_pkg::RAD_W-1:0]  sq_rad_r  [SQ_N];
  logic [SQR_W-1:0]           sq_rem_nxt  [SQ_N];
  logic [amp_pkg::ROOT_W-1:0] sq_root_nxt [SQ_N];
  logic [amp_pkg::RAD_W-1:0]  sq_rad_nxt  [SQ_N];

  logic [amp_pkg::SQ_W-1:0]   ss6;
  logic [amp_pkg::SQ_W-1:0]   ss_dly_r [SS_DLY];
  logic [amp_pkg::DEN_W-1:0]  den55;

  logic [amp_pkg::ISO_W-1:0]  iso6;
  logic [amp_pkg::DY_W-1:0]   dy6 [NENT];
  logic [amp_pkg::DIFF_W-1:0] diff_nxt [NENT];
  logic [amp_pkg::DIFF_W-1:0] diff7_r [NENT];
  logic [NENT-1:0]            oneg_nxt;
  logic [ONEG_W-1:0]          oneg_sh_r [NENT];
  logic [amp_pkg::SCL_W-1:0]  scl10 [NENT];
  logic [amp_pkg::SCL_W-1:0]  num_dly_r [NENT][NUM_DLY];
  logic [amp_pkg::ENT_W-1:0]  ent_res [NENT];
  logic [NENT-1:0]            sat_res;
  logic [amp_pkg::ENT_W-1:0]  ent_fin [NENT];

  amp_pkg::out_item_t         wdata;
  amp_pkg::out_item_t         mem [FIFO_DEPTH];
  amp_pkg::out_item_t         out_data_r;
  logic                       out_valid_r;
  logic [AW-1:0]              wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           inflight_r;
  logic                       wr_en, rd_en;

  logic [CNT_W:0]             held_cnt;
  logic                       out_coinc;
  logic                       coinc_form;

  // request handshake and credit for the output queue
  assign in_stall = (inflight_r == CNT_W'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_scale_r <= amp_pkg::MASS_SCALE_RST;
      coef_rr_r    <= amp_pkg::COEF_RR_RST;
      coef_iso_r   <= amp_pkg::COEF_ISO_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        amp_pkg::REG_MASS_SCALE: mass_scale_r <= cfg_wdata;
        amp_pkg::REG_COEF_RR:    coef_rr_r    <= cfg_wdata;
        amp_pkg::REG_COEF_ISO:   coef_iso_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ST_RES-1:1], in_acc};
    end
  end

  // stage one: separation vector as sign and magnitude
  always_comb begin
    dif[0] = amp_pkg::MAG_W'(in_data.pos_a_x) - amp_pkg::MAG_W'(in_data.pos_b_x);
    dif[1] = amp_pkg::MAG_W'(in_data.pos_a_y) - amp_pkg::MAG_W'(in_data.pos_b_y);
    dif[2] = amp_pkg::MAG_W'(in_data.pos_a_z) - amp_pkg::MAG_W'(in_data.pos_b_z);
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = dif[k][amp_pkg::MAG_W-1] ? amp_pkg::MAG_W'(-dif[k]) : amp_pkg::MAG_W'(dif[k]);
    end
  end

  // stage three sum of squares
  assign s_nxt = prod2_r[ENT_XX] + prod2_r[ENT_YY] + prod2_r[ENT_ZZ];

  // stages one to three and the control line
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag1_r[k] <= mag_nxt[k];
    end
    ctl_r[1].neg  <= {dif[2][amp_pkg::MAG_W-1], dif[1][amp_pkg::MAG_W-1],
                      dif[0][amp_pkg::MAG_W-1]};
    ctl_r[1].zero <= 1'b0;
    ctl_r[1].last <= in_data.last_pair;
    for (int k = 0; k < NENT; k++) begin
      prod2_r[k] <= amp_pkg::PROD_W'(mag1_r[PICK_I[k]]) *
                    amp_pkg::PROD_W'(mag1_r[PICK_J[k]]);
      prod3_r[k] <= prod2_r[k];
    end
    s3_r <= s_nxt;
    for (int k = 2; k <= ST_RES; k++) begin
      if (k == ST_S) begin
        ctl_r[k].neg  <= ctl_r[k-1].neg;
        ctl_r[k].zero <= (s_nxt == '0);
        ctl_r[k].last <= ctl_r[k-1].last;
      end else begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // square root of s * 2^32, two radicand bits per stage
  always_comb begin
    logic [SQR_W-1:0]           rem_in, cur, trial;
    logic [amp_pkg::ROOT_W-1:0] root_in;
    logic [amp_pkg::RAD_W-1:0]  rad_in;
    for (int k = 0; k < SQ_N; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = {s3_r, {amp_pkg::SQRT_SH{1'b0}}};
      end else begin
        rem_in  = sq_rem_r[k-1];
        root_in = sq_root_r[k-1];
        rad_in  = sq_rad_r[k-1];
      end
      cur   = {rem_in[SQR_W-3:0], rad_in[amp_pkg::RAD_W-1 -: 2]};
      trial = SQR_W'({root_in, 2'b01});
      if (cur >= trial) begin
        sq_rem_nxt[k]  = cur - trial;
        sq_root_nxt[k] = {root_in[amp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = cur;
        sq_root_nxt[k] = {root_in[amp_pkg::ROOT_W-2:0], 1'b0};
      end
      sq_rad_nxt[k] = rad_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_N; k++) begin
      sq_rem_r[k]  <= sq_rem_nxt[k];
      sq_root_r[k] <= sq_root_nxt[k];
      sq_rad_r[k]  <= sq_rad_nxt[k];
    end
  end

  // denominator s^2 * |r|
  amp_mul #(.WA(amp_pkg::SUM_W), .WB(amp_pkg::SUM_W)) u_ss (
    .clk (clk),
    .a   (s3_r),
    .b   (s3_r),
    .p   (ss6)
  );

  always_ff @(posedge clk) begin
    ss_dly_r[0] <= ss6;
    for (int k = 1; k < SS_DLY; k++) begin
      ss_dly_r[k] <= ss_dly_r[k-1];
    end
  end

  amp_mul #(.WA(amp_pkg::SQ_W), .WB(amp_pkg::ROOT_W)) u_den (
    .clk (clk),
    .a   (ss_dly_r[SS_DLY-1]),
    .b   (sq_root_r[SQ_N-1]),
    .p   (den55)
  );

  // isotropic term shared by the diagonal entries
  amp_mul #(.WA(amp_pkg::CFG_W), .WB(amp_pkg::SUM_W)) u_iso (
    .clk (clk),
    .a   (coef_iso_r),
    .b   (s3_r),
    .p   (iso6)
  );

  // signed difference of the two terms per entry
  always_comb begin
    logic [amp_pkg::DIFF_W-1:0] pos, negp;
    logic                       x;
    for (int k = 0; k < NENT; k++) begin
      x    = ctl_r[ST_DY].neg[PICK_I[k]] ^ ctl_r[ST_DY].neg[PICK_J[k]];
      pos  = ((PICK_I[k] == PICK_J[k]) ? amp_pkg::DIFF_W'(iso6) : '0) +
             (x ? amp_pkg::DIFF_W'(dy6[k]) : '0);
      negp = x ? '0 : amp_pkg::DIFF_W'(dy6[k]);
      if (pos >= negp) begin
        diff_nxt[k] = pos - negp;
        oneg_nxt[k] = 1'b0;
      end else begin
        diff_nxt[k] = negp - pos;
        oneg_nxt[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NENT; k++) begin
      diff7_r[k]   <= diff_nxt[k];
      oneg_sh_r[k] <= {oneg_sh_r[k][ONEG_W-2:0], oneg_nxt[k]};
      num_dly_r[k][0] <= scl10[k];
      for (int m = 1; m < NUM_DLY; m++) begin
        num_dly_r[k][m] <= num_dly_r[k][m-1];
      end
    end
  end

  // per entry: dyadic product, gain, divide
  for (genvar g = 0; g < NENT; g++) begin : g_ent
    amp_mul #(.WA(amp_pkg::CFG_W), .WB(amp_pkg::PROD_W)) u_dy (
      .clk (clk),
      .a   (coef_rr_r),
      .b   (prod3_r[g]),
      .p   (dy6[g])
    );

    amp_mul #(.WA(amp_pkg::CFG_W), .WB(amp_pkg::DIFF_W)) u_scl (
      .clk (clk),
      .a   (mass_scale_r),
      .b   (diff7_r[g]),
      .p   (scl10[g])
    );

    amp_div u_div (
      .clk   (clk),
      .num   ({num_dly_r[g][NUM_DLY-1], {amp_pkg::FRAC_SH{1'b0}}}),
      .den   (den55),
      .neg   (oneg_sh_r[g][ONEG_W-1]),
      .entry (ent_res[g]),
      .sat   (sat_res[g])
    );
  end

  // coincident pairs override the quotient
  always_comb begin
    for (int k = 0; k < NENT; k++) begin
      if (ctl_r[ST_RES].zero) begin
        ent_fin[k] = (PICK_I[k] == PICK_J[k]) ? amp_pkg::ENT_MAX : '0;
      end else begin
        ent_fin[k] = ent_res[k];
      end
    end
    wdata.m_xx = ent_fin[0];
    wdata.m_xy = ent_fin[1];
    wdata.m_xz = ent_fin[2];
    wdata.m_yy = ent_fin[3];
    wdata.m_yz = ent_fin[4];
    wdata.m_zz = ent_fin[5];
    priority if (ctl_r[ST_RES].zero) begin
      wdata.pair_status = amp_pkg::STAT_COINC;
    end else if (sat_res != '0) begin
      wdata.pair_status = amp_pkg::STAT_SAT;
    end else begin
      wdata.pair_status = amp_pkg::STAT_OK;
    end
    wdata.last_out = ctl_r[ST_RES].last;
  end

  // output queue
  assign wr_en = vld_r[ST_RES];
  assign rd_en = (cnt_r != '0) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      inflight_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      cnt_r       <= cnt_r + CNT_W'(wr_en) - CNT_W'(rd_en);
      inflight_r  <= inflight_r + CNT_W'(in_acc) - CNT_W'(out_acc);
      out_valid_r <= rd_en || (out_valid_r && out_stall);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // terms for the checks
  assign held_cnt   = (CNT_W+1)'(cnt_r) + (CNT_W+1)'(out_valid_r);
  assign out_coinc  = out_valid_r && (out_data_r.pair_status == amp_pkg::STAT_COINC);
  assign coinc_form = (out_data_r.m_xy == '0) && (out_data_r.m_xz == '0) &&
                      (out_data_r.m_yz == '0) && (out_data_r.m_xx == amp_pkg::ENT_MAX);

  // checks
  `AMP_ASSERT_ALWAYS(a_queue_bound, cnt_r <= CNT_W'(FIFO_DEPTH), "output queue overflow")
  `AMP_ASSERT_ALWAYS(a_credit, held_cnt <= (CNT_W+1)'(inflight_r), "queue over credit")
  `AMP_ASSERT_IMPL(a_res_credit, vld_r[ST_RES], inflight_r != '0, "result without request")
  `AMP_ASSERT_IMPL(a_coinc, out_coinc, coinc_form, "coincident result malformed")

endmodule

/* test/tb_added_mass_pair_block.sv */
// regression bench for the added-mass pair block: directed pairs, register sweeps, random pairs
// predicts each request's six block entries with wide integer math, checks results in order
// depends on amp_pkg and the added_mass_pair_block top level
`timescale 1ns / 1ps

module tb_added_mass_pair_block;

  localparam logic [amp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 600000;

  typedef bit [255:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  amp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  amp_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [amp_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [amp_pkg::CFG_W-1:0] cfg_wdata = '0;

  // shadow of the gain registers
  bit [31:0] gain_scale, gain_rr, gain_iso;

  amp_pkg::out_item_t block_queue[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  added_mass_pair_block i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("added_mass_pair_block regression: fail");
      $finish;
    end
  end

  // floor of the square root of a value below 2^100
  function automatic bit [49:0] root_floor(bit [99:0] v);
    bit [49:0] res;
    bit [99:0] c;
    res = '0;
    for (int b = 49; b >= 0; b--) begin
      c = {50'd0, res | (50'd1 << b)};
      if (c * c <= v) res = c[49:0];
    end
    return res;
  endfunction

  // six block entries of one pair under the current gains
  function automatic amp_pkg::out_item_t pair_block(amp_pkg::in_item_t p);
    amp_pkg::out_item_t r;
    bit [32:0] mag[3];
    bit neg[3];
    bit signed [32:0] d;
    wide_t s, den, pos, negp, dy, q;
    bit [31:0] ent[6];
    bit out_neg, sat;
    int ii[6] = '{0, 0, 0, 1, 1, 2};
    int jj[6] = '{0, 1, 2, 1, 2, 2};
    logic signed [31:0] av[3];
    logic signed [31:0] bv[3];
    av = '{p.pos_a_x, p.pos_a_y, p.pos_a_z};
    bv = '{p.pos_b_x, p.pos_b_y, p.pos_b_z};
    s = '0;
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = $signed({av[k][31], av[k]}) - $signed({bv[k][31], bv[k]});
      neg[k] = d[32];
      mag[k] = neg[k] ? -d : d;
      s = s + wide_t'(mag[k]) * wide_t'(mag[k]);
    end
    r = '0;
    r.last_out = p.last_pair;
    if (s == 0) begin
      r.m_xx = amp_pkg::ENT_MAX;
      r.m_yy = amp_pkg::ENT_MAX;
      r.m_zz = amp_pkg::ENT_MAX;
      r.pair_status = amp_pkg::STAT_COINC;
      return r;
    end
    den = s * s * wide_t'(root_floor({s[67:0], 32'd0}));
    for (int e = 0; e < 6; e++) begin
      dy = wide_t'(gain_rr) * wide_t'(mag[ii[e]]) * wide_t'(mag[jj[e]]);
      pos = (ii[e] == jj[e]) ? wide_t'(gain_iso) * s : '0;
      negp = '0;
      if (neg[ii[e]] != neg[jj[e]]) pos = pos + dy;
      else negp = dy;
      out_neg = negp > pos;
      q = ((wide_t'(gain_scale) * (out_neg ? negp - pos : pos - negp)) << 48) / den;
      if (out_neg) begin
        if (q > 256'h8000_0000) begin
          sat = 1'b1;
          ent[e] = amp_pkg::ENT_MIN;
        end else ent[e] = -q[31:0];
      end else begin
        if (q > 256'h7FFF_FFFF) begin
          sat = 1'b1;
          ent[e] = amp_pkg::ENT_MAX;
        end else ent[e] = q[31:0];
      end
    end
    r.m_xx = ent[0];
    r.m_xy = ent[1];
    r.m_xz = ent[2];
    r.m_yy = ent[3];
    r.m_yz = ent[4];
    r.m_zz = ent[5];
    r.pair_status = sat ? amp_pkg::STAT_SAT : amp_pkg::STAT_OK;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result side: random stall bursts, compare against oldest prediction
  always @(posedge clk) begin
    amp_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (block_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
      end else begin
        want = block_queue.pop_front();
        check_field("m_xx", want.m_xx, out_data.m_xx);
        check_field("m_xy", want.m_xy, out_data.m_xy);
        check_field("m_xz", want.m_xz, out_data.m_xz);
        check_field("m_yy", want.m_yy, out_data.m_yy);
        check_field("m_yz", want.m_yz, out_data.m_yz);
        check_field("m_zz", want.m_zz, out_data.m_zz);
        check_field("pair_status", want.pair_status, out_data.pair_status);
        check_field("last_out", want.last_out, out_data.last_out);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one request; caller stands at a rising edge
  task automatic send_pair(amp_pkg::in_item_t p);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    block_queue.push_back(pair_block(p));
  endtask

  // hold off until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (block_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [amp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      amp_pkg::REG_MASS_SCALE: gain_scale = val;
      amp_pkg::REG_COEF_RR:    gain_rr = val;
      amp_pkg::REG_COEF_ISO:   gain_iso = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [31:0] ms, logic [31:0] cr, logic [31:0] ci);
    write_reg(amp_pkg::REG_MASS_SCALE, ms);
    write_reg(amp_pkg::REG_COEF_RR, cr);
    write_reg(amp_pkg::REG_COEF_ISO, ci);
  endtask

  function automatic amp_pkg::in_item_t make_pair(logic [31:0] ax, logic [31:0] ay,
                                                  logic [31:0] az, logic [31:0] bx,
                                                  logic [31:0] by, logic [31:0] bz,
                                                  logic last);
    amp_pkg::in_item_t p;
    p = '{ax, ay, az, bx, by, bz, last};
    return p;
  endfunction

  // mostly nearby spheres, some far apart, a few coincident
  function automatic amp_pkg::in_item_t random_pair();
    amp_pkg::in_item_t p;
    int mode;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom)};
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      p.pos_b_x = p.pos_a_x;
      p.pos_b_y = p.pos_a_y;
      p.pos_b_z = p.pos_a_z;
    end else if (mode <= 6) begin
      p.pos_b_x = p.pos_a_x - ($signed($urandom) >>> $urandom_range(6, 30));
      p.pos_b_y = p.pos_a_y - ($signed($urandom) >>> $urandom_range(6, 30));
      p.pos_b_z = p.pos_a_z - ($signed($urandom) >>> $urandom_range(6, 30));
    end
    return p;
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn, one;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    one = 32'h0001_0000;
    // coincident positions, at zero and at the extremes
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
    send_pair(make_pair(mx, mn, mx, mx, mn, mx, 1'b1));
    // largest separation on every axis and mixed signs
    send_pair(make_pair(mx, mx, mx, mn, mn, mn, 1'b0));
    send_pair(make_pair(mn, mx, mn, mx, mn, mx, 1'b1));
    // one lsb apart: entries saturate
    send_pair(make_pair(1, 0, 0, 0, 0, 0, 1'b0));
    send_pair(make_pair(0, 0, 0, 1, 1, 1, 1'b0));
    // unit distance along x and y, twice that along z, and on diagonals
    send_pair(make_pair(one, 0, 0, 0, 0, 0, 1'b0));
    send_pair(make_pair(0, -one, 0, 0, 0, 0, 1'b0));
    send_pair(make_pair(0, 0, 2 * one, 0, 0, 0, 1'b1));
    send_pair(make_pair(one, one, one, 0, 0, 0, 1'b0));
    send_pair(make_pair(-one, one, -one, one, -one, one, 1'b0));
    drain();
    // gain extremes, including zero gain and zero coefficients
    set_gains(0, amp_pkg::COEF_RR_RST, amp_pkg::COEF_ISO_RST);
    send_pair(make_pair(one, one, 0, 0, 0, 0, 1'b0));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b1));
    drain();
    set_gains(mx | mn, 0, mx | mn);
    send_pair(make_pair(one, 2 * one, 3 * one, 0, 0, 0, 1'b0));
    send_pair(make_pair(mx, mx, mx, mn, mn, mn, 1'b0));
    drain();
    set_gains(mx | mn, mx | mn, 0);
    send_pair(make_pair(one, -one, 3 * one, 0, 0, 0, 1'b1));
    send_pair(make_pair(mx, mx, mx, mn, mn, mn, 1'b0));
    // an index past the last register changes nothing
    drain();
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    send_pair(make_pair(one, 0, one, 0, one, 0, 1'b0));
    drain();
  endtask

  task automatic test_random_gains();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_gains(amp_pkg::MASS_SCALE_RST, amp_pkg::COEF_RR_RST, amp_pkg::COEF_ISO_RST);
        1: set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: set_gains(1, 1, 1);
        default: set_gains($urandom, $urandom >> $urandom_range(0, 16),
                           $urandom >> $urandom_range(0, 16));
      endcase
      for (int n = 0; n < 100; n++) send_pair(random_pair());
      drain();
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    set_gains(amp_pkg::MASS_SCALE_RST, amp_pkg::COEF_RR_RST, amp_pkg::COEF_ISO_RST);
    for (int n = 0; n < 130; n++) send_pair(random_pair());
    drain();
  endtask

  initial begin
    gain_scale = amp_pkg::MASS_SCALE_RST;
    gain_rr = amp_pkg::COEF_RR_RST;
    gain_iso = amp_pkg::COEF_ISO_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_gains();
    test_back_to_back();
    if (errors == 0) begin
      $display("added_mass_pair_block regression: pass");
    end else begin
      $display("added_mass_pair_block regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/amp_pkg.sv
hdl/amp_mul.sv
hdl/amp_div.sv
hdl/added_mass_pair_block.sv
test/tb_added_mass_pair_block.sv
